>>> hdl/drsc_pkg.sv
`timescale 1ns / 1ps
package drsc_pkg;

   localparam int MV_W       = 12;
   localparam int PERIODS_W  = 16;
   localparam int SHORT_W    = 8;
   localparam int WET_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // item kinds
   localparam logic [1:0] FUNC_SENSOR     = 2'd0;
   localparam logic [1:0] FUNC_MOVE_START = 2'd1;
   localparam logic [1:0] FUNC_MOVE_END   = 2'd2;
   localparam logic [1:0] FUNC_WIN_ACK    = 2'd3;

   // rack states
   localparam logic [2:0] RACK_RETRACTED  = 3'd0;
   localparam logic [2:0] RACK_EXTENDING  = 3'd1;
   localparam logic [2:0] RACK_EXTENDED   = 3'd2;
   localparam logic [2:0] RACK_RETRACTING = 3'd3;
   localparam logic [2:0] RACK_ALARM      = 3'd4;

   // window states
   localparam logic [1:0] WIN_CLOSED  = 2'd0;
   localparam logic [1:0] WIN_OPENING = 2'd1;
   localparam logic [1:0] WIN_OPEN    = 2'd2;
   localparam logic [1:0] WIN_CLOSING = 2'd3;

   localparam logic [1:0] BUZZ_NONE  = 2'd0;
   localparam logic [1:0] BUZZ_ALARM = 2'd1;
   localparam logic [1:0] BUZZ_CHIRP = 2'd2;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_OPEN  = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;

   localparam logic [1:0] KEY_IDLE = 2'd0;
   localparam logic [1:0] KEY_ONE  = 2'd1;
   localparam logic [1:0] KEY_TWO  = 2'd2;

   localparam logic [WET_W-1:0]     WET_MAX     = '1;
   localparam logic [PERIODS_W-1:0] PERIODS_MAX = '1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_S1_LOW      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_S1_HIGH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_S2_LOW      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_S2_HIGH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_PRESS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAIN_THRESH = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAIN_CONFIRM = 3'd7;

   typedef struct packed {
      logic [MV_W-1:0]      s1_low_mv;
      logic [MV_W-1:0]      s1_high_mv;
      logic [MV_W-1:0]      s2_low_mv;
      logic [MV_W-1:0]      s2_high_mv;
      logic [SHORT_W-1:0]   short_press_periods;
      logic [PERIODS_W-1:0] long_press_periods;
      logic [MV_W-1:0]      rain_threshold_mv;
      logic [WET_W-1:0]     rain_confirm_count;
   } cfg_type;

   typedef struct packed {
      logic [2:0]           rack;
      logic [1:0]           window;
      logic                 lock;
      logic                 stop;
      logic                 rain;
      logic [WET_W-1:0]     wet_count;
      logic                 resume;
      logic [1:0]           held_key;
      logic [PERIODS_W-1:0] held_periods;
      logic                 long_done;
   } state_type;

   typedef struct packed {
      logic [1:0]      func;
      logic            button_event;
      logic            pir_event;
      logic [MV_W-1:0] rain_mv;
      logic            rain_valid;
      logic [MV_W-1:0] key_mv;
      logic            key_valid;
      logic            link_ready;
      logic            move_extend;
      logic            move_interrupted;
      logic            ack_open;
      logic            ack_ok;
   } item_type;

   typedef struct packed {
      logic [2:0] rack_mode;
      logic [1:0] window_mode;
      logic       lock_on;
      logic       stop_request;
      logic       rain_on;
      logic [1:0] buzz_kind;
      logic [1:0] window_command;
      logic       resume_extend;
   } result_type;

endpackage

>>> hdl/drsc_if.sv
`timescale 1ns / 1ps
interface drsc_req_if import drsc_pkg::*;;
   logic            valid;
   logic            ready;
   logic [1:0]      func;
   logic            button_event;
   logic            pir_event;
   logic [MV_W-1:0] rain_mv;
   logic            rain_valid;
   logic [MV_W-1:0] key_mv;
   logic            key_valid;
   logic            link_ready;
   logic            move_extend;
   logic            move_interrupted;
   logic            ack_open;
   logic            ack_ok;

   modport source (output valid, func, button_event, pir_event, rain_mv, rain_valid,
                   key_mv, key_valid, link_ready, move_extend, move_interrupted,
                   ack_open, ack_ok, input ready);
   modport sink (input valid, func, button_event, pir_event, rain_mv, rain_valid,
                 key_mv, key_valid, link_ready, move_extend, move_interrupted,
                 ack_open, ack_ok, output ready);
endinterface

interface drsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] rack_mode;
   logic [1:0] window_mode;
   logic       lock_on;
   logic       stop_request;
   logic       rain_on;
   logic [1:0] buzz_kind;
   logic [1:0] window_command;
   logic       resume_extend;

   modport source (output valid, rack_mode, window_mode, lock_on, stop_request, rain_on,
                   buzz_kind, window_command, resume_extend, input ready);
   modport sink (input valid, rack_mode, window_mode, lock_on, stop_request, rain_on,
                 buzz_kind, window_command, resume_extend, output ready);
endinterface

interface drsc_csr_if import drsc_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/drsc_step.sv
`timescale 1ns / 1ps
module drsc_step
   import drsc_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  cur,
   input  item_type   item,
   output state_type  nxt,
   output result_type res
);

   logic [1:0] buzz;
   logic [1:0] cmd;
   logic [1:0] key;
   logic       wet;
   logic [WET_W-1:0] wet_inc;

   always_comb begin
      nxt  = cur;
      buzz = BUZZ_NONE;
      cmd  = CMD_NONE;
      key  = KEY_IDLE;
      wet  = item.rain_mv < cfg.rain_threshold_mv;
      wet_inc = (cur.wet_count < WET_MAX) ? cur.wet_count + 1'b1 : cur.wet_count;

      unique case (item.func)
         FUNC_SENSOR: begin
            if (item.pir_event) nxt.stop = 1'b1;

            if (item.button_event && !cur.lock) begin
               unique case (cur.rack)
                  RACK_RETRACTED: begin
                     nxt.rack = RACK_EXTENDING;
                     nxt.stop = 1'b0;
                  end
                  RACK_EXTENDED: begin
                     nxt.rack = RACK_RETRACTING;
                     nxt.stop = 1'b0;
                  end
                  RACK_EXTENDING: begin
                     nxt.rack = RACK_RETRACTING;
                     nxt.stop = 1'b1;
                  end
                  RACK_RETRACTING: begin
                     nxt.rack = RACK_EXTENDING;
                     nxt.stop = 1'b1;
                  end
                  RACK_ALARM: begin
                     nxt.rack = cur.resume ? RACK_EXTENDING : RACK_RETRACTING;
                     nxt.stop = 1'b0;
                  end
                  default: ;
               endcase
            end

            if (item.pir_event &&
                (nxt.rack == RACK_EXTENDING || nxt.rack == RACK_RETRACTING)) begin
               nxt.resume = (nxt.rack == RACK_EXTENDING);
               nxt.rack   = RACK_ALARM;
               buzz       = BUZZ_ALARM;
            end

            if (item.rain_valid) begin
               if (wet) begin
                  nxt.wet_count = wet_inc;
                  if (wet_inc >= cfg.rain_confirm_count) begin
                     nxt.wet_count = cfg.rain_confirm_count;
                     nxt.rain      = 1'b1;
                     if (nxt.rack == RACK_EXTENDED || nxt.rack == RACK_EXTENDING) begin
                        nxt.stop = 1'b1;
                        nxt.rack = RACK_RETRACTING;
                     end
                     if ((cur.window == WIN_OPEN || cur.window == WIN_OPENING) &&
                         item.link_ready) begin
                        cmd        = CMD_CLOSE;
                        nxt.window = WIN_CLOSING;
                     end
                  end
               end else begin
                  nxt.wet_count = '0;
                  nxt.rain      = 1'b0;
               end
            end

            if (!nxt.rain && item.key_valid) begin
               // key one window has priority over key two
               if (item.key_mv >= cfg.s1_low_mv && item.key_mv < cfg.s1_high_mv)
                  key = KEY_ONE;
               else if (item.key_mv >= cfg.s2_low_mv && item.key_mv < cfg.s2_high_mv)
                  key = KEY_TWO;

               if (key != KEY_IDLE) begin
                  if (key == cur.held_key) begin
                     if (cur.held_periods < PERIODS_MAX)
                        nxt.held_periods = cur.held_periods + 1'b1;
                     if (nxt.held_periods == cfg.long_press_periods && !cur.long_done) begin
                        nxt.lock      = (key == KEY_ONE);
                        buzz          = BUZZ_CHIRP;
                        nxt.long_done = 1'b1;
                     end
                  end else begin
                     nxt.held_key     = key;
                     nxt.held_periods = PERIODS_W'(1);
                     nxt.long_done    = 1'b0;
                  end
               end else if (cur.held_key != KEY_IDLE) begin
                  // release: short press may command the window
                  if (cur.held_periods >= {{(PERIODS_W-SHORT_W){1'b0}}, cfg.short_press_periods}
                      && !cur.long_done && !cur.lock && item.link_ready) begin
                     if (cur.held_key == KEY_ONE && cur.window == WIN_CLOSED) begin
                        cmd        = CMD_OPEN;
                        nxt.window = WIN_OPENING;
                     end else if (cur.held_key == KEY_TWO && cur.window == WIN_OPEN) begin
                        cmd        = CMD_CLOSE;
                        nxt.window = WIN_CLOSING;
                     end
                  end
                  nxt.held_key     = KEY_IDLE;
                  nxt.held_periods = '0;
                  nxt.long_done    = 1'b0;
               end
            end
         end
         FUNC_MOVE_START: ;
         FUNC_MOVE_END: begin
            if (cur.stop || item.move_interrupted) begin
               nxt.resume = item.move_extend;
               nxt.rack   = RACK_ALARM;
               buzz       = BUZZ_ALARM;
            end else if (item.move_extend && cur.rack == RACK_EXTENDING) begin
               nxt.rack = RACK_EXTENDED;
            end else if (!item.move_extend && cur.rack == RACK_RETRACTING) begin
               nxt.rack = RACK_RETRACTED;
            end
         end
         FUNC_WIN_ACK: begin
            if (item.ack_ok) nxt.window = item.ack_open ? WIN_OPEN : WIN_CLOSED;
            else nxt.window = item.ack_open ? WIN_CLOSED : WIN_OPEN;
         end
         default: ;
      endcase

      res.rack_mode      = nxt.rack;
      res.window_mode    = nxt.window;
      res.lock_on        = nxt.lock;
      res.stop_request   = nxt.stop;
      res.rain_on        = nxt.rain;
      res.buzz_kind      = buzz;
      res.window_command = cmd;
      res.resume_extend  = nxt.resume;
   end

endmodule

>>> hdl/drying_rack_safety_controller_top.sv
`timescale 1ns / 1ps
// Safety controller for a motorized drying rack and a remote window. Every item
// (sensor period, motion start, motion end, window acknowledgement) produces one
// result holding the rack, window, lock, stop and rain state after the item plus any
// buzzer request or window command it raised. Items pass through an input register,
// combinational state update logic and a result register, and one item is taken
// every cycle while the result side keeps up. Configuration registers are written
// over the csr channel, which is always ready; the user must write them only while
// no item is in flight, since the block does not enforce this.
module drying_rack_safety_controller_top
   import drsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   drsc_req_if.sink   req_chan,
   drsc_rsp_if.source rsp_chan,
   drsc_csr_if.sink   csr_chan
);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   item_type   in_ff, req_item;
   logic       in_valid_ff;
   result_type out_ff, step_res;
   logic       out_valid_ff;
   logic       advance;

   // configuration
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_S1_LOW:       cfg_in.s1_low_mv = csr_chan.data[MV_W-1:0];
            CSR_S1_HIGH:      cfg_in.s1_high_mv = csr_chan.data[MV_W-1:0];
            CSR_S2_LOW:       cfg_in.s2_low_mv = csr_chan.data[MV_W-1:0];
            CSR_S2_HIGH:      cfg_in.s2_high_mv = csr_chan.data[MV_W-1:0];
            CSR_SHORT_PRESS:  cfg_in.short_press_periods = csr_chan.data[SHORT_W-1:0];
            CSR_LONG_PRESS:   cfg_in.long_press_periods = csr_chan.data[PERIODS_W-1:0];
            CSR_RAIN_THRESH:  cfg_in.rain_threshold_mv = csr_chan.data[MV_W-1:0];
            CSR_RAIN_CONFIRM: cfg_in.rain_confirm_count = csr_chan.data[WET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.s1_low_mv           <= MV_W'(0);
         cfg_ff.s1_high_mv          <= MV_W'(500);
         cfg_ff.s2_low_mv           <= MV_W'(500);
         cfg_ff.s2_high_mv          <= MV_W'(1500);
         cfg_ff.short_press_periods <= SHORT_W'(3);
         cfg_ff.long_press_periods  <= PERIODS_W'(60);
         cfg_ff.rain_threshold_mv   <= MV_W'(1300);
         cfg_ff.rain_confirm_count  <= WET_W'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline handshake
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      req_item.func             = req_chan.func;
      req_item.button_event     = req_chan.button_event;
      req_item.pir_event        = req_chan.pir_event;
      req_item.rain_mv          = req_chan.rain_mv;
      req_item.rain_valid       = req_chan.rain_valid;
      req_item.key_mv           = req_chan.key_mv;
      req_item.key_valid        = req_chan.key_valid;
      req_item.link_ready       = req_chan.link_ready;
      req_item.move_extend      = req_chan.move_extend;
      req_item.move_interrupted = req_chan.move_interrupted;
      req_item.ack_open         = req_chan.ack_open;
      req_item.ack_ok           = req_chan.ack_ok;
   end

   drsc_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (in_ff),
      .nxt  (state_in),
      .res  (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_chan.ready) in_valid_ff <= req_chan.valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) in_ff <= req_item;
      if (advance) out_ff <= step_res;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.rack_mode      = out_ff.rack_mode;
   assign rsp_chan.window_mode    = out_ff.window_mode;
   assign rsp_chan.lock_on        = out_ff.lock_on;
   assign rsp_chan.stop_request   = out_ff.stop_request;
   assign rsp_chan.rain_on        = out_ff.rain_on;
   assign rsp_chan.buzz_kind      = out_ff.buzz_kind;
   assign rsp_chan.window_command = out_ff.window_command;
   assign rsp_chan.resume_extend  = out_ff.resume_extend;

   // an alarm buzz always leaves the rack in the alarm state
   a_buzz_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.buzz_kind == BUZZ_ALARM |-> rsp_chan.rack_mode == RACK_ALARM)
      else $error("alarm buzz without rack alarm");

   // a window command leaves the window in the matching transit state
   a_cmd_window: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.window_command != CMD_NONE |->
         (rsp_chan.window_command == CMD_OPEN && rsp_chan.window_mode == WIN_OPENING) ||
         (rsp_chan.window_command == CMD_CLOSE && rsp_chan.window_mode == WIN_CLOSING))
      else $error("window command and window state disagree");

   // the input side only stalls while an item waits in the input register
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && out_valid_ff && !rsp_chan.ready)
      else $error("input stalled without a blocked item");

   // a new result appears only after an item advanced
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result without an item");

endmodule

>>> bench/tb_drying_rack_safety_controller_top.sv
`timescale 1ns / 1ps
module tb_drying_rack_safety_controller_top;
   import drsc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int PHASE_ITEMS = 160;

   // Tracks rack/window state and checks every result in order.
   class rack_scoreboard;
      cfg_type    cfg;
      state_type  st;
      result_type due_results[$];
      int         mismatches;

      function new();
         cfg = '{s1_low_mv: 12'd0, s1_high_mv: 12'd500, s2_low_mv: 12'd500,
                 s2_high_mv: 12'd1500, short_press_periods: 8'd3,
                 long_press_periods: 16'd60, rain_threshold_mv: 12'd1300,
                 rain_confirm_count: 4'd3};
         st = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_S1_LOW:       cfg.s1_low_mv = val[MV_W-1:0];
            CSR_S1_HIGH:      cfg.s1_high_mv = val[MV_W-1:0];
            CSR_S2_LOW:       cfg.s2_low_mv = val[MV_W-1:0];
            CSR_S2_HIGH:      cfg.s2_high_mv = val[MV_W-1:0];
            CSR_SHORT_PRESS:  cfg.short_press_periods = val[SHORT_W-1:0];
            CSR_LONG_PRESS:   cfg.long_press_periods = val[PERIODS_W-1:0];
            CSR_RAIN_THRESH:  cfg.rain_threshold_mv = val[MV_W-1:0];
            CSR_RAIN_CONFIRM: cfg.rain_confirm_count = val[WET_W-1:0];
            default: ;
         endcase
      endfunction

      function result_type advance(item_type it);
         result_type r;
         logic [1:0] buzz, cmd, key_now;
         buzz = BUZZ_NONE;
         cmd = CMD_NONE;
         case (it.func)
            FUNC_SENSOR: begin
               if (it.pir_event) st.stop = 1'b1;
               if (it.button_event && !st.lock) begin
                  case (st.rack)
                     RACK_RETRACTED: begin
                        st.rack = RACK_EXTENDING;
                        st.stop = 1'b0;
                     end
                     RACK_EXTENDED: begin
                        st.rack = RACK_RETRACTING;
                        st.stop = 1'b0;
                     end
                     RACK_EXTENDING: begin
                        st.rack = RACK_RETRACTING;
                        st.stop = 1'b1;
                     end
                     RACK_RETRACTING: begin
                        st.rack = RACK_EXTENDING;
                        st.stop = 1'b1;
                     end
                     RACK_ALARM: begin
                        st.stop = 1'b0;
                        st.rack = st.resume ? RACK_EXTENDING : RACK_RETRACTING;
                     end
                     default: ;
                  endcase
               end
               if (it.pir_event && (st.rack == RACK_EXTENDING || st.rack == RACK_RETRACTING))
               begin
                  st.resume = (st.rack == RACK_EXTENDING);
                  st.rack = RACK_ALARM;
                  buzz = BUZZ_ALARM;
               end
               if (it.rain_valid) begin
                  if (it.rain_mv < cfg.rain_threshold_mv) begin
                     if (st.wet_count != WET_MAX) st.wet_count = st.wet_count + 1'b1;
                     if (st.wet_count >= cfg.rain_confirm_count) begin
                        st.wet_count = cfg.rain_confirm_count;
                        st.rain = 1'b1;
                        if (st.rack == RACK_EXTENDED || st.rack == RACK_EXTENDING) begin
                           st.stop = 1'b1;
                           st.rack = RACK_RETRACTING;
                        end
                        if ((st.window == WIN_OPEN || st.window == WIN_OPENING) &&
                            it.link_ready) begin
                           cmd = CMD_CLOSE;
                           st.window = WIN_CLOSING;
                        end
                     end
                  end else begin
                     st.wet_count = '0;
                     st.rain = 1'b0;
                  end
               end
               if (!st.rain && it.key_valid) begin
                  key_now = KEY_IDLE;
                  if (it.key_mv >= cfg.s1_low_mv && it.key_mv < cfg.s1_high_mv)
                     key_now = KEY_ONE;
                  else if (it.key_mv >= cfg.s2_low_mv && it.key_mv < cfg.s2_high_mv)
                     key_now = KEY_TWO;
                  if (key_now != KEY_IDLE) begin
                     if (key_now == st.held_key) begin
                        if (st.held_periods != PERIODS_MAX)
                           st.held_periods = st.held_periods + 1'b1;
                        if (st.held_periods == cfg.long_press_periods && !st.long_done) begin
                           st.lock = (key_now == KEY_ONE);
                           buzz = BUZZ_CHIRP;
                           st.long_done = 1'b1;
                        end
                     end else begin
                        st.held_key = key_now;
                        st.held_periods = PERIODS_W'(1);
                        st.long_done = 1'b0;
                     end
                  end else if (st.held_key != KEY_IDLE) begin
                     // release: short press may command the window
                     if (st.held_periods >= cfg.short_press_periods && !st.long_done &&
                         !st.lock) begin
                        if (st.held_key == KEY_ONE && st.window == WIN_CLOSED) begin
                           if (it.link_ready) begin
                              cmd = CMD_OPEN;
                              st.window = WIN_OPENING;
                           end
                        end else if (st.held_key == KEY_TWO && st.window == WIN_OPEN) begin
                           if (it.link_ready) begin
                              cmd = CMD_CLOSE;
                              st.window = WIN_CLOSING;
                           end
                        end
                     end
                     st.held_key = KEY_IDLE;
                     st.held_periods = '0;
                     st.long_done = 1'b0;
                  end
               end
            end
            FUNC_MOVE_END: begin
               if (st.stop || it.move_interrupted) begin
                  st.resume = it.move_extend;
                  st.rack = RACK_ALARM;
                  buzz = BUZZ_ALARM;
               end else if (it.move_extend && st.rack == RACK_EXTENDING) begin
                  st.rack = RACK_EXTENDED;
               end else if (!it.move_extend && st.rack == RACK_RETRACTING) begin
                  st.rack = RACK_RETRACTED;
               end
            end
            FUNC_WIN_ACK: begin
               if (it.ack_ok) st.window = it.ack_open ? WIN_OPEN : WIN_CLOSED;
               else st.window = it.ack_open ? WIN_CLOSED : WIN_OPEN;
            end
            default: ;
         endcase
         r.rack_mode = st.rack;
         r.window_mode = st.window;
         r.lock_on = st.lock;
         r.stop_request = st.stop;
         r.rain_on = st.rain;
         r.buzz_kind = buzz;
         r.window_command = cmd;
         r.resume_extend = st.resume;
         return r;
      endfunction

      function void note_item(item_type it);
         due_results.push_back(advance(it));
      endfunction

      function void cmp(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: result with no pending item", $realtime);
            return;
         end
         want = due_results.pop_front();
         cmp("rack_mode", want.rack_mode, got.rack_mode);
         cmp("window_mode", want.window_mode, got.window_mode);
         cmp("lock_on", want.lock_on, got.lock_on);
         cmp("stop_request", want.stop_request, got.stop_request);
         cmp("rain_on", want.rain_on, got.rain_on);
         cmp("buzz_kind", want.buzz_kind, got.buzz_kind);
         cmp("window_command", want.window_command, got.window_command);
         cmp("resume_extend", want.resume_extend, got.resume_extend);
      endfunction
   endclass

   logic clock;
   logic reset;

   drsc_req_if req_bus();
   drsc_rsp_if rsp_bus();
   drsc_csr_if csr_bus();

   drying_rack_safety_controller_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   rack_scoreboard sb;
   int items_sent = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holdoffs_asked = 0;
   int holdoffs_done = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side ready, with random stalls and requested long hold-offs
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoffs_asked != holdoffs_done) begin
            holdoffs_done = holdoffs_asked;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : monitor
      item_type   seen;
      result_type got;
      bit         moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.func = req_bus.func;
            seen.button_event = req_bus.button_event;
            seen.pir_event = req_bus.pir_event;
            seen.rain_mv = req_bus.rain_mv;
            seen.rain_valid = req_bus.rain_valid;
            seen.key_mv = req_bus.key_mv;
            seen.key_valid = req_bus.key_valid;
            seen.link_ready = req_bus.link_ready;
            seen.move_extend = req_bus.move_extend;
            seen.move_interrupted = req_bus.move_interrupted;
            seen.ack_open = req_bus.ack_open;
            seen.ack_ok = req_bus.ack_ok;
            sb.note_item(seen);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.rack_mode = rsp_bus.rack_mode;
            got.window_mode = rsp_bus.window_mode;
            got.lock_on = rsp_bus.lock_on;
            got.stop_request = rsp_bus.stop_request;
            got.rain_on = rsp_bus.rain_on;
            got.buzz_kind = rsp_bus.buzz_kind;
            got.window_command = rsp_bus.window_command;
            got.resume_extend = rsp_bus.resume_extend;
            sb.check_result(got);
            moved = 1'b1;
         end
         if (csr_bus.valid && csr_bus.ready) moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic bit in_window(logic [MV_W-1:0] v, logic [MV_W-1:0] lo,
                                    logic [MV_W-1:0] hi);
      return v >= lo && v < hi;
   endfunction

   // a ladder level that decodes as no key; full scale never falls in a window
   function automatic logic [MV_W-1:0] no_key_level();
      logic [MV_W-1:0] v;
      for (int i = 0; i < 8; i++) begin
         v = MV_W'($urandom_range(4095, 0));
         if (!in_window(v, sb.cfg.s1_low_mv, sb.cfg.s1_high_mv) &&
             !in_window(v, sb.cfg.s2_low_mv, sb.cfg.s2_high_mv))
            return v;
      end
      return '1;
   endfunction

   function automatic logic [MV_W-1:0] key_level(logic [1:0] k);
      logic [MV_W-1:0] v;
      v = '1;
      if (k == KEY_ONE) begin
         if (sb.cfg.s1_high_mv > sb.cfg.s1_low_mv)
            v = MV_W'($urandom_range(sb.cfg.s1_high_mv - 1, sb.cfg.s1_low_mv));
      end else if (sb.cfg.s2_high_mv > sb.cfg.s2_low_mv) begin
         for (int i = 0; i < 8; i++) begin
            v = MV_W'($urandom_range(sb.cfg.s2_high_mv - 1, sb.cfg.s2_low_mv));
            if (!in_window(v, sb.cfg.s1_low_mv, sb.cfg.s1_high_mv)) break;
         end
         // key one window shadows key two here
         if (in_window(v, sb.cfg.s1_low_mv, sb.cfg.s1_high_mv)) v = '1;
      end
      return v;
   endfunction

   function automatic item_type random_item();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(item_type)-1:0];
   endfunction

   function automatic item_type sensor(bit btn, bit pir, logic [MV_W-1:0] rain_mv,
                                       bit rain_ok, logic [MV_W-1:0] key_mv, bit key_ok,
                                       bit link);
      item_type it;
      it = random_item();
      it.func = FUNC_SENSOR;
      it.button_event = btn;
      it.pir_event = pir;
      it.rain_mv = rain_mv;
      it.rain_valid = rain_ok;
      it.key_mv = key_mv;
      it.key_valid = key_ok;
      it.link_ready = link;
      return it;
   endfunction

   // sensor period with a dry rain reading and no key activity
   function automatic item_type quiet_sensor();
      return sensor(1'b0, 1'b0, MV_W'($urandom_range(4095, sb.cfg.rain_threshold_mv)),
                    1'($urandom_range(1)), no_key_level(), 1'b0, $urandom_range(9) != 0);
   endfunction

   function automatic item_type motion(logic [1:0] f, bit ext, bit intr);
      item_type it;
      it = random_item();
      it.func = f;
      it.move_extend = ext;
      it.move_interrupted = intr;
      return it;
   endfunction

   function automatic item_type ack(bit open_cmd, bit ok);
      item_type it;
      it = random_item();
      it.func = FUNC_WIN_ACK;
      it.ack_open = open_cmd;
      it.ack_ok = ok;
      return it;
   endfunction

   task automatic push(input item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= it.func;
      req_bus.button_event <= it.button_event;
      req_bus.pir_event <= it.pir_event;
      req_bus.rain_mv <= it.rain_mv;
      req_bus.rain_valid <= it.rain_valid;
      req_bus.key_mv <= it.key_mv;
      req_bus.key_valid <= it.key_valid;
      req_bus.link_ready <= it.link_ready;
      req_bus.move_extend <= it.move_extend;
      req_bus.move_interrupted <= it.move_interrupted;
      req_bus.ack_open <= it.ack_open;
      req_bus.ack_ok <= it.ack_ok;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.due_results.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_reg(idx, val);
   endtask

   task automatic program_regs(logic [CSR_DATA_W-1:0] s1_lo, s1_hi, s2_lo, s2_hi,
                               short_p, long_p, thresh, confirm);
      write_reg(CSR_S1_LOW, s1_lo);
      write_reg(CSR_S1_HIGH, s1_hi);
      write_reg(CSR_S2_LOW, s2_lo);
      write_reg(CSR_S2_HIGH, s2_hi);
      write_reg(CSR_SHORT_PRESS, short_p);
      write_reg(CSR_LONG_PRESS, long_p);
      write_reg(CSR_RAIN_THRESH, thresh);
      write_reg(CSR_RAIN_CONFIRM, confirm);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic directed_items();
      push(sensor(0, 0, 12'hFFF, 1, 12'hFFF, 1, 0));
      push(sensor(1, 0, 0, 0, 0, 0, 1));
      push(motion(FUNC_MOVE_START, 0, 0));
      push(sensor(1, 0, 0, 0, 0, 0, 1));        // reverse while moving
      push(motion(FUNC_MOVE_END, 0, 0));        // stop still raised
      push(sensor(1, 1, 0, 0, 0, 0, 1));        // resume, then presence
      push(sensor(1, 0, 0, 0, 0, 0, 1));
      push(motion(FUNC_MOVE_END, 0, 0));
      push(sensor(1, 0, 0, 0, 0, 0, 1));
      push(motion(FUNC_MOVE_END, 1, 0));
      push(sensor(1, 0, 0, 0, 0, 0, 1));
      push(motion(FUNC_MOVE_END, 0, 1));
      repeat (3) push(sensor(0, 0, 0, 0, 12'd0, 1, 1));
      push(sensor(0, 0, 0, 0, 12'hFFF, 1, 1));  // short press opens
      push(ack(1, 1));
      repeat (3) push(sensor(0, 0, 0, 0, 12'd1499, 1, 1));
      push(sensor(0, 0, 0, 0, 12'hFFF, 1, 0));  // link busy, no command
      repeat (3) push(sensor(0, 0, 12'd1299, 1, 0, 0, 1));
      push(ack(1, 0));
      push(sensor(0, 0, 12'd1300, 1, 0, 0, 0));
   endtask

   task automatic random_sequence();
      item_type        it;
      int              pick, n, cap;
      logic [1:0]      k;
      logic [MV_W-1:0] lvl;
      pick = $urandom_range(99);
      if (pick < 30) begin
         // key hold of random length, then release
         k = $urandom_range(1) ? KEY_ONE : KEY_TWO;
         lvl = key_level(k);
         cap = (sb.cfg.long_press_periods > 28) ? 30 : sb.cfg.long_press_periods + 2;
         n = $urandom_range(cap, 1);
         for (int i = 0; i < n; i++) begin
            it = quiet_sensor();
            it.key_valid = 1'b1;
            it.key_mv = ($urandom_range(3) == 0) ? key_level(k) : lvl;
            if ($urandom_range(19) == 0) it.button_event = 1'b1;
            push(it);
         end
         it = quiet_sensor();
         it.key_valid = 1'b1;
         it.key_mv = no_key_level();
         push(it);
      end else if (pick < 55) begin
         it = quiet_sensor();
         it.button_event = 1'b1;
         it.pir_event = ($urandom_range(4) == 0);
         push(it);
         if ($urandom_range(1)) push(motion(FUNC_MOVE_START, 1'($urandom_range(1)), 0));
         if ($urandom_range(3) == 0) begin
            it = quiet_sensor();
            it.pir_event = 1'b1;
            push(it);
         end
         push(motion(FUNC_MOVE_END, 1'($urandom_range(1)), $urandom_range(7) == 0));
      end else if (pick < 70) begin
         push(ack(1'($urandom_range(1)), $urandom_range(3) != 0));
      end else if (pick < 80) begin
         n = $urandom_range(sb.cfg.rain_confirm_count + 2, 1);
         repeat (n) begin
            it = quiet_sensor();
            it.rain_valid = 1'b1;
            it.rain_mv = (sb.cfg.rain_threshold_mv == 0) ? 12'hFFF :
                         MV_W'($urandom_range(sb.cfg.rain_threshold_mv - 1, 0));
            it.link_ready = ($urandom_range(3) != 0);
            it.key_valid = 1'($urandom_range(1));
            it.key_mv = key_level($urandom_range(1) ? KEY_ONE : KEY_TWO);
            push(it);
         end
         if ($urandom_range(9) < 7) begin
            it = quiet_sensor();
            it.rain_valid = 1'b1;
            push(it);
         end
      end else begin
         repeat ($urandom_range(3, 1)) push(random_item());
      end
   endtask

   task automatic run_phase(int send_pct, int stall_pct, int count, bit holdoff,
                            bit pause_mid);
      int first;
      bit held, paused;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      first = items_sent;
      held = 1'b0;
      paused = 1'b0;
      while (items_sent - first < count) begin
         if (holdoff && !held && items_sent - first >= 5) begin
            held = 1'b1;
            holdoffs_asked++;
         end
         if (pause_mid && !paused && items_sent - first >= count / 2) begin
            paused = 1'b1;
            drain();
         end
         random_sequence();
      end
      drain();
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_SENSOR;
      req_bus.button_event = 1'b0;
      req_bus.pir_event = 1'b0;
      req_bus.rain_mv = '0;
      req_bus.rain_valid = 1'b0;
      req_bus.key_mv = '0;
      req_bus.key_valid = 1'b0;
      req_bus.link_ready = 1'b0;
      req_bus.move_extend = 1'b0;
      req_bus.move_interrupted = 1'b0;
      req_bus.ack_open = 1'b0;
      req_bus.ack_ok = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_S1_LOW;
      csr_bus.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      drain();

      program_regs(0, 800, 800, 2000, 1, 4, 2000, 1);
      run_phase(0, 0, PHASE_ITEMS, 0, 0);
      program_regs(4095, 4095, 0, 4095, 255, 16'hFFFF, 0, 15);
      run_phase(62, 0, PHASE_ITEMS, 0, 0);
      program_regs(1000, 3000, 200, 1200, 2, 1, 4095, 2);
      run_phase(0, 62, PHASE_ITEMS, 1, 0);
      program_regs(0, 4095, 0, 4095, 3, 6, 1300, 15);
      run_phase(23, 23, PHASE_ITEMS, 0, 0);
      // upper bits beyond each register width are dropped
      program_regs(16'hF000, 300, 300, 900, 0, 0, 3000, 16'h0010);
      run_phase(0, 0, PHASE_ITEMS, 0, 1);
      program_regs(0, 500, 500, 1500, 3, 3, 1300, 3);
      run_phase(0, 62, PHASE_ITEMS, 0, 0);
      program_regs(100, 600, 600, 3500, 5, 12, 2500, 4);
      run_phase(62, 0, PHASE_ITEMS, 0, 0);

      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
